// ===== src/wrrh_pkg.sv =====
// ----------------------------------------------------------------------------
// Water ripple height step: shared package
// Widths, register indexes, reset values and default sizes of the ripple
// core; its arithmetic stage uses the widths.
// ----------------------------------------------------------------------------
package wrrh_pkg;

    // Height samples are signed bytes on both sides of the block.
    localparam int HEIGHT_W = 8;

    // Column and row fields of a result are one byte each.
    localparam int COORD_W = 8;

    // Configuration registers are all nine bits wide.
    localparam int CFG_W      = 9;
    localparam int CFG_ADDR_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DAMPING      = 2'd2;

    // Register values after reset.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd240;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd240;
    localparam logic [CFG_W-1:0] DAMPING_RST      = 9'd248;

    // Smallest frame side that still has an interior pixel.
    localparam int MIN_DIM = 3;

    // Default line store depth and frame height limit.
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

endpackage

// ===== src/wrrh_ram.sv =====
// ----------------------------------------------------------------------------
// Water ripple height step: generic line store RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wrrh_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/wrrh_calc.sv =====
// ----------------------------------------------------------------------------
// Water ripple height step: height arithmetic
// Halves the neighbor sum toward zero, subtracts the old height, applies the
// Q1.8 damping with truncation toward zero and saturates to a signed byte.
// ----------------------------------------------------------------------------
module wrrh_calc (
    input  logic signed [wrrh_pkg::HEIGHT_W-1:0] left_h,
    input  logic signed [wrrh_pkg::HEIGHT_W-1:0] right_h,
    input  logic signed [wrrh_pkg::HEIGHT_W-1:0] up_h,
    input  logic signed [wrrh_pkg::HEIGHT_W-1:0] down_h,
    input  logic signed [wrrh_pkg::HEIGHT_W-1:0] old_h,
    input  logic        [wrrh_pkg::CFG_W-1:0]    damping,
    output logic signed [wrrh_pkg::HEIGHT_W-1:0] new_height
);

    localparam int SUM_W  = wrrh_pkg::HEIGHT_W + 2;
    localparam int HALF_W = SUM_W - 1;
    localparam int DIFF_W = SUM_W;
    localparam int MAG_W  = DIFF_W - 1;
    localparam int PROD_W = MAG_W + wrrh_pkg::CFG_W;
    localparam int Q_W    = PROD_W - 8;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_adj;
    logic signed [HALF_W-1:0] half;
    logic signed [DIFF_W-1:0] diff;
    logic                     neg;
    logic        [DIFF_W-1:0] diff_abs;
    logic        [MAG_W-1:0]  mag;
    logic        [PROD_W-1:0] prod;
    logic        [Q_W-1:0]    q;

    always_comb begin
        sum = SUM_W'(left_h) + SUM_W'(right_h) + SUM_W'(up_h) + SUM_W'(down_h);
        // Adding one to a negative sum before the shift rounds toward zero.
        sum_adj  = sum + $signed({{(SUM_W-1){1'b0}}, sum[SUM_W-1]});
        half     = HALF_W'(sum_adj >>> 1);
        diff     = DIFF_W'(half) - DIFF_W'(old_h);
        neg      = diff[DIFF_W-1];
        diff_abs = neg ? DIFF_W'(-diff) : DIFF_W'(diff);
        mag      = diff_abs[MAG_W-1:0];
        prod     = PROD_W'(mag) * PROD_W'(damping);
        q        = prod[PROD_W-1:8];
        if (neg) begin
            if (q > Q_W'(128)) begin
                new_height = -8'sd128;
            end else begin
                new_height = wrrh_pkg::HEIGHT_W'(-$signed({1'b0, q}));
            end
        end else begin
            if (q > Q_W'(127)) begin
                new_height = 8'sd127;
            end else begin
                new_height = wrrh_pkg::HEIGHT_W'(q);
            end
        end
    end

endmodule

// ===== src/water_ripple_height_step_core.sv =====
// ----------------------------------------------------------------------------
// Water ripple height step core
// Streams the current and previous height maps in raster order and produces
// the damped new height of every interior pixel.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle: a pair of signed bytes, the
// current and previous height at one raster position, with the current
// height in s_tdata[7:0]. The block never stalls its input unless a
// finished result is waiting while m_tready is low and the new item would
// produce another one. The new height of interior pixel (c, r-1) appears
// on the master side the cycle after the item at (c, r) is accepted, so
// results trail the input by one row; edge pixels produce no result. The
// rate is set by four line stores of MAX_WIDTH entries, each one RAM with
// a registered read port whose address runs one column ahead of the input;
// the row above is kept twice so that columns c and c+1 are read in the
// same cycle. The stores start undefined and need no clearing pass: a frame
// of at least three rows writes every entry it reads. m_tlast marks the
// last interior result of a frame. frame_width and frame_height are clamped
// to 3..MAX_WIDTH and 3..MAX_HEIGHT. The user must write configuration
// only while the block is idle; the block itself does not enforce this,
// and the column and row counters are not cleared by a write.
// ----------------------------------------------------------------------------
module water_ripple_height_step_core #(
    parameter int MAX_WIDTH  = wrrh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wrrh_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration write port.
    input  logic                              cfg_we,
    input  logic [wrrh_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wrrh_pkg::CFG_W-1:0]        cfg_wdata,

    // Input item stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [2*wrrh_pkg::HEIGHT_W-1:0]   s_tdata,   // cur_height, prev_height

    // Result item stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [3*wrrh_pkg::COORD_W-1:0]    m_tdata,   // new_height, col, row
    output logic                              m_tlast    // frame_done
);

    localparam int HW     = wrrh_pkg::HEIGHT_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DW_W   = $clog2(MAX_WIDTH + 1);
    localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int MAXD_W = (DW_W > DH_W) ? DW_W : DH_W;
    localparam int BASE_W = (MAXD_W > wrrh_pkg::CFG_W) ? MAXD_W : wrrh_pkg::CFG_W;
    // One spare bit so that counter plus one never wraps in a compare.
    localparam int CMP_W  = BASE_W + 1;

    // Configuration registers.
    logic [wrrh_pkg::CFG_W-1:0] frame_width_reg;
    logic [wrrh_pkg::CFG_W-1:0] frame_height_reg;
    logic [wrrh_pkg::CFG_W-1:0] damping_reg;

    // Raster position of the next input item.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    // Row above at the previous column.
    logic signed [HW-1:0] held_left_reg;

    // Output register.
    logic                   out_valid_reg;
    logic signed [HW-1:0]   out_height_reg;
    logic [wrrh_pkg::COORD_W-1:0] out_col_reg;
    logic [wrrh_pkg::COORD_W-1:0] out_row_reg;
    logic                   out_last_reg;

    logic signed [HW-1:0] cur_h;
    logic signed [HW-1:0] prev_h;
    logic                 s_accept;

    logic [CMP_W-1:0] width_raw;
    logic [CMP_W-1:0] height_raw;
    logic [CMP_W-1:0] width_eff;
    logic [CMP_W-1:0] height_eff;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] row_ext;
    logic             emit;
    logic             last_pix;
    logic             col_wrap;
    logic             row_wrap;

    logic [COL_W-1:0] rd_col;
    logic [COL_W-1:0] rd_col_right;

    logic signed [HW-1:0] above_h;
    logic signed [HW-1:0] right_h;
    logic signed [HW-1:0] two_above_h;
    logic signed [HW-1:0] old_h;
    logic signed [HW-1:0] new_h;

    assign cur_h  = s_tdata[HW-1:0];
    assign prev_h = s_tdata[2*HW-1:HW];

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= wrrh_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= wrrh_pkg::FRAME_HEIGHT_RST;
            damping_reg      <= wrrh_pkg::DAMPING_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wrrh_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                wrrh_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                wrrh_pkg::REG_DAMPING:      damping_reg      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame geometry: clamp the sizes, classify the current position and step it.
    // ------------------------------------------------------------------
    always_comb begin
        width_raw  = CMP_W'(frame_width_reg);
        height_raw = CMP_W'(frame_height_reg);
        priority if (width_raw < CMP_W'(wrrh_pkg::MIN_DIM)) begin
            width_eff = CMP_W'(wrrh_pkg::MIN_DIM);
        end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
        priority if (height_raw < CMP_W'(wrrh_pkg::MIN_DIM)) begin
            height_eff = CMP_W'(wrrh_pkg::MIN_DIM);
        end else if (height_raw > CMP_W'(MAX_HEIGHT)) begin
            height_eff = CMP_W'(MAX_HEIGHT);
        end else begin
            height_eff = height_raw;
        end

        col_ext = CMP_W'(col_reg);
        row_ext = CMP_W'(row_reg);

        // An interior pixel of the row above is complete once the pixel
        // below it arrives.
        emit = (row_ext >= CMP_W'(2)) && (row_ext + CMP_W'(1) <= height_eff)
            && (col_ext >= CMP_W'(1)) && (col_ext + CMP_W'(2) <= width_eff);
        last_pix = (row_ext + CMP_W'(1) == height_eff)
            && (col_ext + CMP_W'(2) == width_eff);

        col_wrap = (col_ext + CMP_W'(1) >= width_eff);
        row_wrap = (row_ext + CMP_W'(1) >= height_eff);

        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : ROW_W'(row_reg + ROW_W'(1));
        end else begin
            col_next = COL_W'(col_reg + COL_W'(1));
            row_next = row_reg;
        end
    end

    // A new item is refused only when it would produce a result and the
    // finished one is still waiting.
    assign s_tready = !out_valid_reg || m_tready || !emit;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            held_left_reg <= above_h;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The read address is the column of the next item, so the
    // registered read data is ready when that item arrives. Writes go to
    // the current column, which is never the one being read.
    // ------------------------------------------------------------------
    assign rd_col       = s_accept ? col_next : col_reg;
    assign rd_col_right = COL_W'(rd_col + COL_W'(1));

    wrrh_ram #(
        .DATA_W (HW),
        .DEPTH  (MAX_WIDTH)
    ) u_above_ram (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (cur_h),
        .rd_addr (rd_col),
        .rd_data (above_h)
    );

    // Second copy of the row above, read one column ahead.
    wrrh_ram #(
        .DATA_W (HW),
        .DEPTH  (MAX_WIDTH)
    ) u_above_right_ram (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (cur_h),
        .rd_addr (rd_col_right),
        .rd_data (right_h)
    );

    wrrh_ram #(
        .DATA_W (HW),
        .DEPTH  (MAX_WIDTH)
    ) u_two_above_ram (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (above_h),
        .rd_addr (rd_col),
        .rd_data (two_above_h)
    );

    wrrh_ram #(
        .DATA_W (HW),
        .DEPTH  (MAX_WIDTH)
    ) u_old_ram (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (prev_h),
        .rd_addr (rd_col),
        .rd_data (old_h)
    );

    // ------------------------------------------------------------------
    // Height arithmetic for the pixel in the row above.
    // ------------------------------------------------------------------
    wrrh_calc u_calc (
        .left_h     (held_left_reg),
        .right_h    (right_h),
        .up_h       (two_above_h),
        .down_h     (cur_h),
        .old_h      (old_h),
        .damping    (damping_reg),
        .new_height (new_h)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_accept && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            out_height_reg <= new_h;
            out_col_reg    <= wrrh_pkg::COORD_W'(col_reg);
            out_row_reg    <= wrrh_pkg::COORD_W'(row_reg - ROW_W'(1));
            out_last_reg   <= last_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_row_reg, out_col_reg, out_height_reg};
    assign m_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && emit |-> !out_valid_reg || m_tready)
        else $error("result overwritten while waiting");

    // The last interior pixel of a frame leaves marked as the frame end.
    a_last_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && emit && last_pix |=> m_tvalid && m_tlast)
        else $error("frame end not marked on last result");

    // At the end of a row the column count returns to zero.
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && col_wrap |=> col_reg == '0)
        else $error("column count did not wrap at row end");

endmodule

// ===== test/water_ripple_height_step_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water ripple height step core: stream checker
// Watches the configuration port and both item streams, keeps its own copy of
// the line stores and counters, predicts every interior result and compares
// what the core delivers against it in order.
// ----------------------------------------------------------------------------
module water_ripple_height_step_core_checker #(
    parameter int MAX_WIDTH  = wrrh_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wrrh_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [wrrh_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [wrrh_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [2*wrrh_pkg::HEIGHT_W-1:0]   s_tdata,   // cur_height, prev_height
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [3*wrrh_pkg::COORD_W-1:0]    m_tdata,   // new_height, col, row
    input  logic                              m_tlast,   // frame_done
    output int                                fail_count,
    output int                                pending
);
    import wrrh_pkg::*;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic                       done;
    } ripple_result_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] damping_reg;

    logic signed [HEIGHT_W-1:0] line_above     [MAX_WIDTH];
    logic signed [HEIGHT_W-1:0] line_two_above [MAX_WIDTH];
    logic signed [HEIGHT_W-1:0] old_line       [MAX_WIDTH];
    logic signed [HEIGHT_W-1:0] left_above;
    int unsigned                col_pos;
    int unsigned                row_pos;

    ripple_result_t expected_heights[$];

    function automatic int unsigned side_of(logic [CFG_W-1:0] v, int unsigned hi);
        if (int'(v) < MIN_DIM) return MIN_DIM;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Q1.8 damping applied to the magnitude, so the shift truncates toward zero.
    function automatic logic signed [HEIGHT_W-1:0] damp_saturate(int v, logic [CFG_W-1:0] d);
        int mag;
        int q;
        mag = (v < 0) ? -v : v;
        q = (mag * int'(d)) >> 8;
        if (v < 0) q = (q > 128) ? -128 : -q;
        else if (q > 127) q = 127;
        return q[HEIGHT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic predict_pixel(input logic signed [HEIGHT_W-1:0] cur,
                                 input logic signed [HEIGHT_W-1:0] prev);
        int unsigned                w;
        int unsigned                h;
        int unsigned                c;
        int unsigned                r;
        int unsigned                above_row;
        int                         sum;
        int                         diff;
        logic signed [HEIGHT_W-1:0] above;
        logic signed [HEIGHT_W-1:0] right;
        ripple_result_t             res;
        w = side_of(width_reg, MAX_WIDTH);
        h = side_of(height_reg, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        if (c < MAX_WIDTH) begin
            above = line_above[c];
            if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2) begin
                right = (c + 1 < MAX_WIDTH) ? line_above[c + 1] : '0;
                sum = left_above + right + line_two_above[c] + cur;
                diff = sum / 2 - old_line[c];
                above_row = r - 1;
                res.height = damp_saturate(diff, damping_reg);
                res.col = c[COORD_W-1:0];
                res.row = above_row[COORD_W-1:0];
                res.done = (r == h - 1) && (c == w - 2);
                expected_heights.push_back(res);
            end
            left_above = above;
            line_two_above[c] = above;
            line_above[c] = cur;
            old_line[c] = prev;
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result();
        ripple_result_t got;
        ripple_result_t want;
        got.height = m_tdata[HEIGHT_W-1:0];
        got.col = m_tdata[HEIGHT_W +: COORD_W];
        got.row = m_tdata[HEIGHT_W + COORD_W +: COORD_W];
        got.done = m_tlast;
        if (expected_heights.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: height %0d col %0d row %0d",
                                      got.height, got.col, got.row));
        end else begin
            want = expected_heights.pop_front();
            if (got.height !== want.height)
                report_mismatch($sformatf("height at (%0d,%0d): got %0d, expected %0d",
                                          want.col, want.row, got.height, want.height));
            if (got.col !== want.col)
                report_mismatch($sformatf("col: got %0d, expected %0d", got.col, want.col));
            if (got.row !== want.row)
                report_mismatch($sformatf("row: got %0d, expected %0d", got.row, want.row));
            if (got.done !== want.done)
                report_mismatch($sformatf("frame_done at (%0d,%0d): got %b, expected %b",
                                          want.col, want.row, got.done, want.done));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            damping_reg = DAMPING_RST;
            for (int i = 0; i < MAX_WIDTH; i++) begin
                line_above[i] = '0;
                line_two_above[i] = '0;
                old_line[i] = '0;
            end
            left_above = '0;
            col_pos = 0;
            row_pos = 0;
            expected_heights.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FRAME_WIDTH:  width_reg = cfg_wdata;
                    REG_FRAME_HEIGHT: height_reg = cfg_wdata;
                    REG_DAMPING:      damping_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_pixel(s_tdata[HEIGHT_W-1:0], s_tdata[HEIGHT_W +: HEIGHT_W]);
            if (m_tvalid && m_tready)
                check_result();
        end
        pending = expected_heights.size();
    end

endmodule

// ===== test/water_ripple_height_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Water ripple height step core: testbench
// Streams height map frames of many sizes and damping values through the core
// with random idling on both sides, and leaves all checking to the stream
// checker that sits beside the core.
// ----------------------------------------------------------------------------
module water_ripple_height_step_core_tb;
    import wrrh_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;

    // The receiver stalls this long once, early in a tall frame, so
    // that the core has to hold a result and push back on its input.
    localparam int LONG_HOLD = 300;

    // No new phase starts once this many items have gone in.
    localparam int ITEM_TARGET = 1700;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 8'h7f;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 8'h80;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_we;
    logic [CFG_ADDR_W-1:0]       cfg_addr;
    logic [CFG_W-1:0]            cfg_wdata;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [2*HEIGHT_W-1:0]       s_tdata;   // cur_height, prev_height
    logic                        m_tvalid;
    logic                        m_tready;
    logic [3*COORD_W-1:0]        m_tdata;   // new_height, col, row
    logic                        m_tlast;   // frame_done

    int fail_count;
    int pending;

    // Shared between the sender and the receiver process.
    bit gaps_off;
    bit long_hold_req;

    // The sender keeps its own idea of where the core stands in the raster,
    // so that it knows when a frame is complete and the width may grow.
    logic [CFG_W-1:0] width_now;
    logic [CFG_W-1:0] height_now;
    int unsigned      pos_col;
    int unsigned      pos_row;
    int               items_sent;

    water_ripple_height_step_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    water_ripple_height_step_core_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned side_of(logic [CFG_W-1:0] v, int unsigned hi);
        if (int'(v) < MIN_DIM) return MIN_DIM;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long gap.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small frames keep the run short; values below three exercise the clamp.
    function automatic logic [CFG_W-1:0] pick_side();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return CFG_W'($urandom_range(0, 2));
        if (roll == 2) return CFG_W'(MIN_DIM);
        return CFG_W'($urandom_range(3, 12));
    endfunction

    // Damping of zero, exactly one, above one (amplifying) and the usual range.
    function automatic logic [CFG_W-1:0] pick_damping();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'd511;
            3: return CFG_W'($urandom_range(257, 510));
            default: return CFG_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Content styles: full range, tiny values around zero where the
    // truncating divide and shift matter most, and saturating extremes.
    function automatic logic [HEIGHT_W-1:0] pick_height(int style);
        int v;
        case (style)
            1: v = int'($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = -128;
                    1: v = 127;
                    2: v = -1;
                    default: v = 0;
                endcase
            end
            default: v = $urandom_range(0, 255);
        endcase
        return v[HEIGHT_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the item
    // was taken, with s_tvalid still high so the next item can follow at once.
    task automatic send_pixel(input logic [HEIGHT_W-1:0] cur, input logic [HEIGHT_W-1:0] prev);
        int          gap;
        int unsigned w;
        int unsigned h;
        gap = gaps_off ? 0 : gap_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {prev, cur};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
        w = side_of(width_now, MAX_W);
        h = side_of(height_now, MAX_H);
        if (pos_col + 1 >= w) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    task automatic send_random_pixel(input int style);
        send_pixel(pick_height(style), pick_height(style));
    endtask

    // Completes the frame in progress, or sends a whole one from its start.
    task automatic finish_frame(input int style);
        do send_random_pixel(style); while (pos_col != 0 || pos_row != 0);
    endtask

    // Registers may only change while nothing is in flight. An item can
    // produce no result, so a few cycles are added after the last result to
    // cover the one cycle the core needs for each item.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (addr)
            REG_FRAME_WIDTH:  width_now = value;
            REG_FRAME_HEIGHT: height_now = value;
            default: ;
        endcase
    endtask

    // Result side: random stalls, switched off together with the sender's idling, plus the
    // one long hold that the sender asks for.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!gaps_off) stall_left = gap_cycles();
            end
        end
    end

    initial begin : stimulus
        int               phase;
        int               frames;
        int               style;
        int               split;
        bit               change_mid_frame;
        logic [CFG_W-1:0] new_width;
        logic [CFG_W-1:0] new_height;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        gaps_off = 1'b0;
        long_hold_req = 1'b0;
        width_now = FRAME_WIDTH_RST;
        height_now = FRAME_HEIGHT_RST;
        pos_col = 0;
        pos_row = 0;
        items_sent = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: two 3x3 frames at the reset damping, back to back
        // with no idling. All neighbors at the top and the old value at the
        // bottom drive the result into positive saturation, and the mirror
        // image into negative saturation.
        write_reg(REG_FRAME_WIDTH, CFG_W'(MIN_DIM));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(MIN_DIM));
        gaps_off = 1'b1;
        repeat (9) send_pixel(HEIGHT_MAX, HEIGHT_MIN);
        repeat (9) send_pixel(HEIGHT_MIN, HEIGHT_MAX);
        wait_idle();
        gaps_off = 1'b0;

        // Random part, one setting per phase. Phase 1 is the widest frame
        // (width given above the limit), phase 3 the tallest (height given
        // above the limit) with the long receiver hold, and phase 2 shrinks
        // both sides mid-frame so that the column counter sits beyond the
        // new width and the row counter beyond the new height.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            change_mid_frame = 1'b0;
            split = 0;
            case (phase)
                1: begin
                    new_width = 9'd511;
                    new_height = CFG_W'(MIN_DIM);
                end
                2: begin
                    new_width = 9'd10;
                    new_height = 9'd8;
                    change_mid_frame = 1'b1;
                    split = 48;
                end
                3: begin
                    new_width = CFG_W'(MIN_DIM);
                    new_height = 9'd300;
                end
                default: begin
                    new_width = pick_side();
                    new_height = pick_side();
                    change_mid_frame = ($urandom_range(0, 3) == 0);
                end
            endcase
            write_reg(REG_FRAME_WIDTH, new_width);
            write_reg(REG_FRAME_HEIGHT, new_height);
            write_reg(REG_DAMPING, pick_damping());

            gaps_off = (phase == 3) || ($urandom_range(0, 4) == 0);
            frames = (phase == 1 || phase == 3) ? 1 : $urandom_range(1, 3);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: style = 0;
                6, 7:             style = 1;
                default:          style = 2;
            endcase

            if (phase == 3) begin
                // A few rows in, results flow on every third item; the hold
                // then backs the core up while items keep being offered.
                repeat (12) send_random_pixel(style);
                long_hold_req = 1'b1;
            end else if (change_mid_frame) begin
                if (split == 0)
                    split = $urandom_range(1, side_of(width_now, MAX_W) *
                                              side_of(height_now, MAX_H) - 1);
                repeat (split) send_random_pixel(style);
                wait_idle();
                if (phase == 2) begin
                    write_reg(REG_FRAME_WIDTH, 9'd4);
                    write_reg(REG_FRAME_HEIGHT, CFG_W'(MIN_DIM));
                end else begin
                    // The width may only shrink here: a wider row would read
                    // line store entries that this frame never wrote.
                    if ($urandom_range(0, 1) == 0)
                        write_reg(REG_FRAME_WIDTH,
                                  CFG_W'($urandom_range(0, side_of(width_now, MAX_W))));
                    write_reg(REG_FRAME_HEIGHT, CFG_W'($urandom_range(0, 15)));
                    if ($urandom_range(0, 1) == 0) write_reg(REG_DAMPING, pick_damping());
                end
            end
            finish_frame(style);
            repeat (frames - 1) finish_frame(style);
            wait_idle();
            phase++;
        end

        // Drain: every expected result has arrived; wait on so that any stray
        // result still shows before the verdict.
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("water_ripple_height_step_core_tb passed");
        end else begin
            $display("water_ripple_height_step_core_tb failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every gap and stall at
    // its longest; reaching it means results went missing or the core hung.
    initial begin : watchdog
        #4_000_000;
        $display("water_ripple_height_step_core_tb failed");
        $finish;
    end

endmodule
